// ----- rtl/lccp_pkg.sv -----
// Shared types, constants and helpers for the coefficient compress/pack block.
`timescale 1ns / 1ps

package lccp_pkg;

  localparam int MODULUS     = 3329;
  localparam int HALF_MOD    = MODULUS / 2;
  // floor(2^32 / MODULUS): quotient estimate is exact or one low
  localparam int RECIP       = 1290167;
  localparam int RECIP_SHIFT = 32;

  localparam int NUM_LANES = 8;
  localparam int COEFF_W   = 13;
  localparam int RED_W     = 12;   // reduced coefficient, 0..3328
  localparam int NUM_W     = 23;   // x * 2^11 + HALF_MOD
  localparam int PROD_W    = 44;   // NUM_W + 21-bit reciprocal
  localparam int QUO_W     = 12;   // quotient, up to 2^11
  localparam int CODE_W    = 11;
  localparam int PACK_W    = 88;
  localparam int SEL_W     = 3;
  localparam int DEPTH_W   = 4;

  typedef enum logic [SEL_W-1:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_5  = 3'd2,
    DEPTH_10 = 3'd3,
    DEPTH_11 = 3'd4
  } depth_sel_e;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic             valid;
    logic [SEL_W-1:0] sel;
  } ctrl_t;

  // Map selector to bit depth; undefined codes saturate to 11.
  function automatic logic [DEPTH_W-1:0] depth_bits(logic [SEL_W-1:0] sel);
    logic [DEPTH_W-1:0] d;
    unique case (sel)
      DEPTH_1:  d = 4'd1;
      DEPTH_4:  d = 4'd4;
      DEPTH_5:  d = 4'd5;
      DEPTH_10: d = 4'd10;
      default:  d = 4'd11;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/lattice_coeff_compress_pack.sv -----
// Top level: eight compression lanes feeding the packing stage.
`timescale 1ns / 1ps

// Lattice coefficient compressor and packer.
// Input: coeff0_i..coeff7_i are taken on a rising edge with start high and
// busy low. busy is held low, so a new group can enter every cycle.
// Each coefficient is reduced mod 3329, compressed to D bits and the eight
// codes are packed little-endian into D bytes (packed_low_o holds bytes 0-7,
// packed_high_o bytes 8-10, byte_count_o = D).
// Output: done_o is high for exactly one cycle with the result; the receiver
// cannot stall it, so nothing is ever held back.
// The result passes two lane stages (reciprocal multiply, then remainder
// correction) and one packing register. Throughput: one group per cycle.
// Configuration: cfg_we_i writes cfg_wdata_i into the depth selector
// (0=1, 1=4, 2=5, 3=10, 4=11 bits, higher codes act as 11). Write it only
// while no group is in flight. Only the packer's copy travels with a group.
// Reset: rst_ni clears the selector to 1 bit and empties the pipeline.
module lattice_coeff_compress_pack
  import lccp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [SEL_W-1:0]          cfg_wdata_i,
  input  logic signed [COEFF_W-1:0] coeff0_i,
  input  logic signed [COEFF_W-1:0] coeff1_i,
  input  logic signed [COEFF_W-1:0] coeff2_i,
  input  logic signed [COEFF_W-1:0] coeff3_i,
  input  logic signed [COEFF_W-1:0] coeff4_i,
  input  logic signed [COEFF_W-1:0] coeff5_i,
  input  logic signed [COEFF_W-1:0] coeff6_i,
  input  logic signed [COEFF_W-1:0] coeff7_i,
  output logic                      done_o,
  output logic [63:0]               packed_low_o,
  output logic [23:0]               packed_high_o,
  output logic [DEPTH_W-1:0]        byte_count_o
);

  logic [SEL_W-1:0]          sel_d, sel_q;
  ctrl_t                     ctrl_s0, ctrl_s1_q, ctrl_s2_q;
  logic signed [COEFF_W-1:0] coeffs [NUM_LANES];
  code_t                     codes  [NUM_LANES];
  logic [DEPTH_W-1:0]        depth;
  logic [PACK_W-1:0]         packed_w;

  assign busy = 1'b0;

  // Depth selector register
  always_comb begin
    sel_d = sel_q;
    if (cfg_we_i) begin
      sel_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= DEPTH_1;
    end else begin
      sel_q <= sel_d;
    end
  end

  // Track transfers through the two lane stages
  always_comb begin
    ctrl_s0.valid = start && !busy;
    ctrl_s0.sel   = sel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s1_q <= '0;
      ctrl_s2_q <= '0;
    end else begin
      ctrl_s1_q <= ctrl_s0;
      ctrl_s2_q <= ctrl_s1_q;
    end
  end

  assign depth = depth_bits(sel_q);

  assign coeffs[0] = coeff0_i;
  assign coeffs[1] = coeff1_i;
  assign coeffs[2] = coeff2_i;
  assign coeffs[3] = coeff3_i;
  assign coeffs[4] = coeff4_i;
  assign coeffs[5] = coeff5_i;
  assign coeffs[6] = coeff6_i;
  assign coeffs[7] = coeff7_i;

  // Compression lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lccp_lane u_lane (
      .clk_i   (clk_i),
      .coeff_i (coeffs[g]),
      .depth_i (depth),
      .code_o  (codes[g])
    );
  end

  // Merge lane codes into the packed word
  lccp_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_s2_q),
    .codes_i      (codes),
    .done_o       (done_o),
    .packed_o     (packed_w),
    .byte_count_o (byte_count_o)
  );

  assign packed_low_o  = packed_w[63:0];
  assign packed_high_o = packed_w[PACK_W-1:64];

endmodule

// ----- rtl/lccp_lane.sv -----
// One compression lane: reduce mod q, scale, round-divide by q over two stages.
`timescale 1ns / 1ps

module lccp_lane
  import lccp_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [COEFF_W-1:0] coeff_i,
  input  logic [DEPTH_W-1:0]        depth_i,
  output code_t                     code_o
);

  localparam logic signed [13:0] MOD_S    = 14'sd3329;
  localparam logic signed [13:0] NEG_LIM  = -14'sd3329;

  logic signed [13:0] v_ext;
  logic signed [13:0] red;
  logic [RED_W-1:0]   x;
  logic [NUM_W-1:0]   num;
  logic [PROD_W-1:0]  prod;

  logic [NUM_W-1:0]   num_d, num_q;
  logic [QUO_W-1:0]   qest_d, qest_q;

  logic [NUM_W:0]     rem;
  logic [QUO_W-1:0]   quo;
  code_t              code_d, code_q;

  // Reduce to the standard representative in [0, q)
  always_comb begin
    v_ext = 14'(coeff_i);
    if (v_ext < NEG_LIM) begin
      red = v_ext + MOD_S + MOD_S;
    end else if (v_ext < 14'sd0) begin
      red = v_ext + MOD_S;
    end else if (v_ext >= MOD_S) begin
      red = v_ext - MOD_S;
    end else begin
      red = v_ext;
    end
    x = red[RED_W-1:0];
  end

  // Scale, add half modulus, estimate quotient by reciprocal
  always_comb begin
    num    = (NUM_W'(x) << depth_i) + NUM_W'(HALF_MOD);
    prod   = PROD_W'(num) * PROD_W'(RECIP);
    num_d  = num;
    qest_d = prod[RECIP_SHIFT +: QUO_W];
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    qest_q <= qest_d;
  end

  // Correct estimate by one where the remainder reaches q
  always_comb begin
    rem    = (NUM_W+1)'(num_q) - (NUM_W+1)'((NUM_W+1)'(qest_q) * (NUM_W+1)'(MODULUS));
    quo    = (rem >= (NUM_W+1)'(MODULUS)) ? qest_q + QUO_W'(1) : qest_q;
    code_d = quo[CODE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

// ----- rtl/lccp_pack.sv -----
// Merge stage: pack eight lane codes little-endian at the selected depth.
`timescale 1ns / 1ps

module lccp_pack
  import lccp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  code_t               codes_i [NUM_LANES],
  output logic                done_o,
  output logic [PACK_W-1:0]   packed_o,
  output logic [DEPTH_W-1:0]  byte_count_o
);

  logic [PACK_W-1:0]  packed_d, packed_q;
  logic [DEPTH_W-1:0] count_d, count_q;
  logic               done_q;

  // Place each code at lane * depth; unused top bits stay zero
  always_comb begin
    packed_d = '0;
    unique case (ctrl_i.sel)
      DEPTH_1: begin
        for (int j = 0; j < NUM_LANES; j++) packed_d[j*1 +: 1] = codes_i[j][0:0];
      end
      DEPTH_4: begin
        for (int j = 0; j < NUM_LANES; j++) packed_d[j*4 +: 4] = codes_i[j][3:0];
      end
      DEPTH_5: begin
        for (int j = 0; j < NUM_LANES; j++) packed_d[j*5 +: 5] = codes_i[j][4:0];
      end
      DEPTH_10: begin
        for (int j = 0; j < NUM_LANES; j++) packed_d[j*10 +: 10] = codes_i[j][9:0];
      end
      default: begin
        for (int j = 0; j < NUM_LANES; j++) packed_d[j*11 +: 11] = codes_i[j][10:0];
      end
    endcase
    count_d = depth_bits(ctrl_i.sel);
  end

  // Register result payload in the same cycle as its strobe
  always_ff @(posedge clk_i) begin
    packed_q <= packed_d;
    count_q  <= count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  assign done_o       = done_q;
  assign packed_o     = packed_q;
  assign byte_count_o = count_q;

endmodule

// ----- rtl/lccp_checker.sv -----
// Port-level checker for the compress/pack block, bound to the top level.
`timescale 1ns / 1ps

module lccp_checker
  import lccp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_i,
  input logic                done_i,
  input logic [63:0]         packed_low_i,
  input logic [23:0]         packed_high_i,
  input logic [DEPTH_W-1:0]  byte_count_i
);

  // Each transfer yields exactly one result, via ctrl_s1_q, ctrl_s2_q and done_q
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3)) |->
      (done_i == $past(start_i && !busy_i, 3)))
    else $error("result strobe does not follow accepted transfer");

  // Byte count is one of the supported depths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (byte_count_i == 4'd1 || byte_count_i == 4'd4 ||
                byte_count_i == 4'd5 || byte_count_i == 4'd10 ||
                byte_count_i == 4'd11))
    else $error("byte count outside supported depths");

  // Bytes beyond the count are zero: high bytes for counts up to 8, all but byte 0 at count 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && byte_count_i <= 4'd8) |-> (packed_high_i == '0))
    else $error("high bytes set for short depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && byte_count_i == 4'd1) |-> (packed_low_i[63:8] == '0))
    else $error("bits beyond one byte set at depth one");

endmodule

bind lattice_coeff_compress_pack lccp_checker u_lccp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start),
  .busy_i        (busy),
  .done_i        (done_o),
  .packed_low_i  (packed_low_o),
  .packed_high_i (packed_high_o),
  .byte_count_i  (byte_count_o)
);
